### sv/rxs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxs_pkg: shared types and constants for the record exchange sorter
// Record layout, store sizing and the key helper used by the sort datapath.
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam int MAX_RECORDS = 8;  // store depth, 2 .. 64
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int TAG_W  = 8;
  localparam int MARK_W = 10;
  localparam int KEY_W  = MARK_W + 2;
  localparam int MEAN_W = 10;

  // floor(key / 3) as (key * 2731) >> 13, exact for key < 4096
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 13;
  localparam logic [RECIP_W-1:0] RECIP = 12'd2731;

  typedef struct packed {
    logic [MARK_W-1:0] second_mark;
    logic [MARK_W-1:0] first_mark;
    logic [TAG_W-1:0]  tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic [KEY_W-1:0] key_of(input rec_t r);
    return KEY_W'(r.first_mark) + (KEY_W'(r.second_mark) << 1);
  endfunction

endpackage

### sv/rxs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxs_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rxs_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/record_exchange_sort_by_weighted_mean_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_exchange_sort_by_weighted_mean_top: batch sorter by weighted mean
// Loads records, sorts them descending by first + 2*second, emits them.
// ----------------------------------------------------------------------------
// Use:
//   A record beat is taken on a rising edge with start high and busy low.
//   Non-last beats are written to the record store and busy stays low.
//   Records past MAX_RECORDS are dropped and the batch is flagged with
//   overflow. A beat with last high (stored or dropped) ends the batch
//   and raises busy.
//   Sort: an exchange sort over the n stored records, one compare per cycle
//   within each pass over j on the shared key unit; the running entry i
//   sits in a register while entries j stream through the store's single
//   read port.
//   Emit: a read-priming state (S_EMIT_RD), then one result per cycle on
//   the result ports, each marked by valid for one cycle, out_last on the
//   final one. Busy drops as the final result is shown; a new batch may
//   start in that cycle.
//   The receiver cannot stall; results are never held.
//   Reset (synchronous, rst high) empties the batch and returns to idle.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_weighted_mean_top
  import rxs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [TAG_W-1:0]  tag,
  input  logic [MARK_W-1:0] first_mark,
  input  logic [MARK_W-1:0] second_mark,
  input  logic              last,
  output logic              valid,
  output logic [TAG_W-1:0]  out_tag,
  output logic [MARK_W-1:0] out_first_mark,
  output logic [MARK_W-1:0] out_second_mark,
  output logic [MEAN_W-1:0] weighted_mean,
  output logic              overflow,
  output logic              out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDI,
    S_GETI,
    S_CMP,
    S_WRI,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  rec_t             cur;
  logic [KEY_W-1:0] cur_key;

  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;
  logic [IDX_W-1:0] raddr;
  rec_t             rdata;

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] count_next;
  logic [KEY_W-1:0] key_rd;
  logic [KEY_W+RECIP_W-1:0] prod;
  logic             swap;

  rxs_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign full       = (count == CNT_W'(MAX_RECORDS));
  assign count_next = full ? count : count + CNT_W'(1);

  // shared key unit: one adder on the read port, feeding compare and mean
  assign key_rd = key_of(rdata);
  assign swap   = (key_rd > cur_key);
  assign prod   = key_rd * RECIP;

  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = cur;
    raddr = i;
    case (state)
      S_IDLE: begin
        we    = accept && !full;
        waddr = count[IDX_W-1:0];
        wdata = '{second_mark: second_mark, first_mark: first_mark, tag: tag};
      end
      S_RDI:     raddr = i;
      S_GETI:    raddr = j;
      S_CMP: begin
        we    = swap;
        waddr = j;
        raddr = j + IDX_W'(1);
      end
      S_WRI:     we = 1'b1;
      S_EMIT_RD: raddr = i;
      S_EMIT:    raddr = i + IDX_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            count   <= count_next;
            dropped <= dropped | full;
            if (last) begin
              i <= '0;
              j <= IDX_W'(1);
              state <= (count_next == CNT_W'(1)) ? S_EMIT_RD : S_RDI;
            end
          end
        end
        S_RDI: state <= S_GETI;
        S_GETI: begin
          cur     <= rdata;
          cur_key <= key_rd;
          state   <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            cur     <= rdata;
            cur_key <= key_rd;
          end
          if (CNT_W'(j) + CNT_W'(1) < count) begin
            j <= j + IDX_W'(1);
          end else begin
            state <= S_WRI;
          end
        end
        S_WRI: begin
          if (CNT_W'(i) + CNT_W'(2) < count) begin
            i     <= i + IDX_W'(1);
            j     <= i + IDX_W'(2);
            state <= S_RDI;
          end else begin
            i     <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          valid           <= 1'b1;
          out_tag         <= rdata.tag;
          out_first_mark  <= rdata.first_mark;
          out_second_mark <= rdata.second_mark;
          weighted_mean   <= prod[RECIP_SHIFT+MEAN_W-1:RECIP_SHIFT];
          overflow        <= dropped;
          out_last        <= (CNT_W'(i) + CNT_W'(1) == count);
          i               <= i + IDX_W'(1);
          if (CNT_W'(i) + CNT_W'(1) == count) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    valid && out_last |-> (count == '0) && !dropped)
    else $error("batch state not cleared after final result");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> busy)
    else $error("last beat did not start the sort");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result shown without a sort pass");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> (j > i) && (CNT_W'(j) < count))
    else $error("compare indexes out of order or range");

  a_no_write_past_count: assert property (@(posedge clk) disable iff (rst)
    we && state != S_IDLE |-> CNT_W'(waddr) < count)
    else $error("sort write beyond stored records");
`endif

endmodule

### sim/record_exchange_sort_by_weighted_mean_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_exchange_sort_by_weighted_mean_top_tb: batch sorter self-check
// Drives record beats in batches of random size, which may overflow the store,
// include tied keys, or carry extreme marks. A tracker class ranks each batch
// the way the block should and checks every emitted record against it.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_weighted_mean_top_tb;
  import rxs_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles with no beat in or out
  localparam int DRAIN_WAIT  = 100;
  localparam int BEAT_TARGET = 200;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [MARK_W-1:0] first_mark;
    logic [MARK_W-1:0] second_mark;
    logic [MEAN_W-1:0] mean;
    logic              overflow;
    logic              fin;
  } ranked_rec_t;

  // Collects the records of the open batch and, on its last beat, queues the
  // records in the order the block must emit them.
  class ranking_board;
    rec_t        batch[MAX_RECORDS];
    int unsigned held;
    bit          dropped;
    ranked_rec_t ranked_due[$];
    int          errors;

    function new();
      held    = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    function int pending();
      return ranked_due.size();
    endfunction

    function logic [KEY_W-1:0] weight(rec_t r);
      logic [KEY_W-1:0] k;
      k = {2'b00, r.first_mark} + {1'b0, r.second_mark, 1'b0};
      return k;
    endfunction

    function void take_record(rec_t r, bit is_last);
      rec_t        t;
      ranked_rec_t e;
      logic [KEY_W-1:0] k;
      if (held < MAX_RECORDS) begin
        batch[held] = r;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (!is_last) return;
      // exchange sort, strict compare keeps the tie order of the block
      for (int i = 0; i + 1 < held; i++) begin
        for (int j = i + 1; j < held; j++) begin
          if (weight(batch[j]) > weight(batch[i])) begin
            t        = batch[i];
            batch[i] = batch[j];
            batch[j] = t;
          end
        end
      end
      for (int i = 0; i < held; i++) begin
        k             = weight(batch[i]);
        e.tag         = batch[i].tag;
        e.first_mark  = batch[i].first_mark;
        e.second_mark = batch[i].second_mark;
        e.mean        = MEAN_W'(k / 3);
        e.overflow    = dropped;
        e.fin         = (i + 1 == held);
        ranked_due.push_back(e);
      end
      held    = 0;
      dropped = 1'b0;
    endfunction

    function void field_cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_ranked(ranked_rec_t got);
      ranked_rec_t want;
      if (ranked_due.size() == 0) begin
        $error("unexpected result beat: tag %0d", got.tag);
        errors++;
        return;
      end
      want = ranked_due.pop_front();
      field_cmp("out_tag", want.tag, got.tag);
      field_cmp("out_first_mark", want.first_mark, got.first_mark);
      field_cmp("out_second_mark", want.second_mark, got.second_mark);
      field_cmp("weighted_mean", want.mean, got.mean);
      field_cmp("overflow", want.overflow, got.overflow);
      field_cmp("out_last", want.fin, got.fin);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [TAG_W-1:0]  tag = '0;
  logic [MARK_W-1:0] first_mark = '0;
  logic [MARK_W-1:0] second_mark = '0;
  logic              last = 1'b0;
  logic              valid;
  logic [TAG_W-1:0]  out_tag;
  logic [MARK_W-1:0] out_first_mark;
  logic [MARK_W-1:0] out_second_mark;
  logic [MEAN_W-1:0] weighted_mean;
  logic              overflow;
  logic              out_last;

  ranking_board board = new();
  int           burst_left = 0;
  int           beats_sent = 0;
  int           quiet = 0;

  record_exchange_sort_by_weighted_mean_top DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .tag             (tag),
    .first_mark      (first_mark),
    .second_mark     (second_mark),
    .last            (last),
    .valid           (valid),
    .out_tag         (out_tag),
    .out_first_mark  (out_first_mark),
    .out_second_mark (out_second_mark),
    .weighted_mean   (weighted_mean),
    .overflow        (overflow),
    .out_last        (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // one record beat; opens a random idle gap when the current burst is spent
  task automatic send_record(input logic [TAG_W-1:0] t, input logic [MARK_W-1:0] m1,
                             input logic [MARK_W-1:0] m2, input bit is_last);
    int gap;
    rec_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    start       <= 1'b1;
    tag         <= t;
    first_mark  <= m1;
    second_mark <= m2;
    last        <= is_last;
    do @(posedge clk); while (busy);
    r.tag         = t;
    r.first_mark  = m1;
    r.second_mark = m2;
    board.take_record(r, is_last);
    burst_left--;
    beats_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [MARK_W-1:0] pick_mark(bit tie_mode);
    int r;
    r = $urandom_range(0, 9);
    if (tie_mode) begin
      case ($urandom_range(0, 4))
        0: return 10'd0;
        1: return 10'd1;
        2: return 10'd2;
        3: return 10'd500;
        default: return 10'd1000;
      endcase
    end
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    if (r == 1) return MARK_W'($urandom_range(1001, 1023));
    return MARK_W'($urandom_range(0, 1000));
  endfunction

  initial begin
    int  n;
    bit  ties;
    int  batches;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone record, all zero
    send_record(8'd0, 10'd0, 10'd0, 1'b1);
    // top of the field ranges, above the nominal mark limit
    send_record(8'd255, 10'd1023, 10'd1023, 1'b0);
    send_record(8'd254, 10'd1000, 10'd1000, 1'b1);
    // equal keys: 2 + 0 = 0 + 2*1, order must follow the exchange pattern
    send_record(8'd10, 10'd2, 10'd0, 1'b0);
    send_record(8'd11, 10'd0, 10'd1, 1'b0);
    send_record(8'd12, 10'd4, 10'd0, 1'b0);
    send_record(8'd13, 10'd2, 10'd1, 1'b1);
    wait_drained();
    // full store, then the last beat is dropped but still closes the batch
    for (int i = 0; i < MAX_RECORDS; i++)
      send_record(8'(8'h80 + i), MARK_W'(i * 100), MARK_W'(900 - i * 100), 1'b0);
    send_record(8'hAA, 10'd555, 10'd555, 1'b1);
    // one more overflow batch, extra non-last beats dropped before last
    for (int i = 0; i < MAX_RECORDS + 2; i++)
      send_record(8'(8'h40 + i), pick_mark(1'b0), pick_mark(1'b0), 1'b0);
    send_record(8'h55, 10'd1, 10'd1, 1'b1);
    wait_drained();

    batches = 0;
    while (beats_sent < BEAT_TARGET) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 3);
        1, 2:    n = MAX_RECORDS;
        default: n = $urandom_range(1, MAX_RECORDS);
      endcase
      ties = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++)
        send_record(8'($urandom_range(0, 255)), pick_mark(ties), pick_mark(ties),
                    i == n - 1);
      batches++;
      if (batches % 9 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    ranked_rec_t got;
    if (!rst && valid) begin
      got.tag         = out_tag;
      got.first_mark  = out_first_mark;
      got.second_mark = out_second_mark;
      got.mean        = weighted_mean;
      got.overflow    = overflow;
      got.fin         = out_last;
      board.match_ranked(got);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || valid) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
